### design/bmfr_pkg.sv
// Package for the broadcast/multicast frame rewriter: sizes, reset values,
// frame class codes and sequencer state type. No dependencies.
package bmfr_pkg;
  localparam int MAX_HEADER_WORDS = 37;
  localparam int HDR_AW = $clog2(MAX_HEADER_WORDS);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_BCAST_SIDE_MAC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MCAST_SIDE_MAC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_IP       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_MAC      = 2'd3;

  localparam logic [31:0] GROUP_IP_RESET  = 32'hEF42_4242;
  localparam logic [47:0] GROUP_MAC_RESET = 48'h0100_5E42_4242;
  localparam logic [15:0] ALL_ONES_WORD   = 16'hFFFF;

  // Word positions within the header.
  localparam int POS_IHL = 7;
  localparam int POS_CSUM = 12;
  localparam int POS_DIP_HI = 15;
  localparam int POS_DIP_LO = 16;
  localparam int POS_UDP_CSUM = 20;

  typedef enum logic [1:0] {
    CLS_UNDECIDED = 2'd0,
    CLS_BCAST     = 2'd1,
    CLS_MCAST     = 2'd2,
    CLS_DROP      = 2'd3
  } frame_class_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_SUM,
    ST_SUM_FIN,
    ST_EMIT,
    ST_STREAM,
    ST_DROP
  } seq_state_t;
endpackage

### design/bcast_mcast_frame_rewriter_core.sv
// Top level of the broadcast/multicast frame rewriter.
// Depends on bmfr_pkg.
//
// The block takes Ethernet frames as 16-bit big-endian beats and buffers the
// Ethernet and IPv4 header (7 + 2*IHL words, at most 37) in a small memory.
// After the last header beat a sequencer classifies the frame (all-ones
// destination MAC means broadcast; otherwise a destination IP equal to
// group_ip means multicast; anything else is dropped), then walks the
// buffered header once through a single shared ones-complement adder to form
// the new IPv4 header checksum, substituting the rewritten fields on the fly,
// one header word per cycle. The rewritten header then bursts out one word a
// cycle while the output does not stall, and the payload streams through one
// beat per accepted input beat. The input is stalled while the header is
// processed, that is during the checksum walk from word 7, the fold of the
// sum and the burst of the header words; the burst also waits while the
// output stalls. The header memory has a single read port, from which both
// the checksum walk and the header burst read.
// Frames with IHL below 5, headers longer than 37 words, and frames that end
// inside the header are dropped silently. Configuration must be written only
// while the block is idle.
module bcast_mcast_frame_rewriter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [15:0]                     in_frame_word,
  input  logic                            in_end_of_frame,
  input  logic                            in_single_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     out_word,
  output logic                            out_last,
  output logic                            out_single_byte,
  output logic                            out_egress_side,
  input  logic                            cfg_we,
  input  logic [bmfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bmfr_pkg::*;

  logic [47:0] bcast_mac_r, mcast_mac_r, group_mac_r;
  logic [31:0] group_ip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcast_mac_r <= '0;
      mcast_mac_r <= '0;
      group_ip_r  <= GROUP_IP_RESET;
      group_mac_r <= GROUP_MAC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BCAST_SIDE_MAC: bcast_mac_r <= cfg_data;
        REG_MCAST_SIDE_MAC: mcast_mac_r <= cfg_data;
        REG_GROUP_IP:       group_ip_r  <= cfg_data[31:0];
        REG_GROUP_MAC:      group_mac_r <= cfg_data;
        default:            ;
      endcase
    end
  end

  // Header memory: one write port, one registered read port.
  logic [15:0] hdr_mem [MAX_HEADER_WORDS];
  logic        mem_we;
  logic [HDR_AW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) hdr_mem[mem_waddr] <= in_frame_word;
    mem_rdata_r <= hdr_mem[mem_raddr];
  end

  seq_state_t   state_r, state_nxt;
  frame_class_t cls_r, cls_nxt;
  logic [15:0]  pos_r, pos_nxt;
  logic [5:0]   hdr_words_r, hdr_words_nxt;
  logic [5:0]   idx_r, idx_nxt;          // word being read or emitted
  logic [5:0]   rd_idx_r, rd_idx_nxt;    // word whose data is in mem_rdata_r
  logic         eof_hdr_r, eof_hdr_nxt;  // frame ended on last header word
  logic         dst_bc_r, dst_bc_nxt;    // destination MAC words all ones so far
  logic [31:0]  dip_r, dip_nxt;
  logic [16:0]  sum_r, sum_nxt;
  logic [15:0]  csum_r, csum_nxt;

  logic         ov_r, ov_nxt;
  logic [15:0]  ow_r, ow_nxt;
  logic         ol_r, ol_nxt, osb_r, osb_nxt, oside_r, oside_nxt;

  logic         in_acc;
  logic         out_free;
  logic [3:0]   ihl;
  logic [15:0]  rw_word;
  logic [16:0]  add_full;
  logic [5:0]   src_off;                 // word offset within the source MAC

  assign out_free = !ov_r || !out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign ihl      = in_frame_word[11:8];
  assign src_off  = rd_idx_r - 6'd3;

  // Rewritten header word for the word currently on the read port.
  always_comb begin
    rw_word = mem_rdata_r;
    case (rd_idx_r)
      6'd0, 6'd1, 6'd2:
        rw_word = (cls_r == CLS_BCAST) ? group_mac_r[47 - 16*rd_idx_r[1:0] -: 16]
                                       : ALL_ONES_WORD;
      6'd3, 6'd4, 6'd5:
        rw_word = (cls_r == CLS_BCAST)
                  ? mcast_mac_r[47 - 16*src_off[1:0] -: 16]
                  : bcast_mac_r[47 - 16*src_off[1:0] -: 16];
      6'(POS_CSUM):     rw_word = 16'h0000;
      6'(POS_DIP_HI):   rw_word = (cls_r == CLS_BCAST) ? group_ip_r[31:16] : ALL_ONES_WORD;
      6'(POS_DIP_LO):   rw_word = (cls_r == CLS_BCAST) ? group_ip_r[15:0] : ALL_ONES_WORD;
      6'(POS_UDP_CSUM): rw_word = 16'h0000;
      default:          ;
    endcase
  end

  // Shared end-around-carry adder.
  assign add_full = {1'b0, sum_r[15:0]} + {16'h0000, sum_r[16]} + {1'b0, rw_word};

  always_comb begin
    state_nxt = state_r; cls_nxt = cls_r; pos_nxt = pos_r;
    hdr_words_nxt = hdr_words_r; idx_nxt = idx_r; rd_idx_nxt = rd_idx_r;
    eof_hdr_nxt = eof_hdr_r; dst_bc_nxt = dst_bc_r; dip_nxt = dip_r;
    sum_nxt = sum_r; csum_nxt = csum_r;
    ov_nxt = ov_r && out_stall; ow_nxt = ow_r; ol_nxt = ol_r;
    osb_nxt = osb_r; oside_nxt = oside_r;
    in_stall = 1'b1; mem_we = 1'b0;
    mem_waddr = pos_r[HDR_AW-1:0];
    mem_raddr = idx_r[HDR_AW-1:0];

    case (state_r)
      ST_COLLECT: begin
        in_stall = 1'b0;
        if (in_acc) begin
          mem_we = 1'b1;
          if (pos_r < 16'd3 && in_frame_word != ALL_ONES_WORD) dst_bc_nxt = 1'b0;
          if (pos_r == 16'(POS_DIP_HI)) dip_nxt[31:16] = in_frame_word;
          if (pos_r == 16'(POS_DIP_LO)) dip_nxt[15:0] = in_frame_word;
          if (pos_r == 16'(POS_IHL)) hdr_words_nxt = 6'd7 + {1'b0, ihl, 1'b0};
          pos_nxt = pos_r + 16'd1;
          if (pos_r == 16'(POS_IHL) &&
              (ihl < 4'd5 || 7 + 2 * int'(ihl) > MAX_HEADER_WORDS)) begin
            if (in_end_of_frame) begin
              state_nxt = ST_COLLECT; pos_nxt = '0; dst_bc_nxt = 1'b1; hdr_words_nxt = '0;
            end else state_nxt = ST_DROP;
          end else if (pos_r > 16'(POS_IHL) &&
                       pos_r[5:0] + 6'd1 == hdr_words_r) begin
            if (in_end_of_frame && in_single_byte) begin
              state_nxt = ST_COLLECT; pos_nxt = '0; dst_bc_nxt = 1'b1; hdr_words_nxt = '0;
            end else begin
              if (dst_bc_r) cls_nxt = CLS_BCAST;
              else if ({dip_r[31:16], in_frame_word} == group_ip_r &&
                       pos_r == 16'(POS_DIP_LO)) cls_nxt = CLS_MCAST;
              else if (dip_r == group_ip_r && pos_r != 16'(POS_DIP_LO)) cls_nxt = CLS_MCAST;
              else cls_nxt = CLS_DROP;
              eof_hdr_nxt = in_end_of_frame;
              if ((dst_bc_r || cls_nxt == CLS_MCAST)) begin
                state_nxt = ST_SUM; idx_nxt = 6'd7; sum_nxt = '0;
              end else if (in_end_of_frame) begin
                state_nxt = ST_COLLECT; pos_nxt = '0; dst_bc_nxt = 1'b1;
                hdr_words_nxt = '0; cls_nxt = CLS_UNDECIDED;
              end else state_nxt = ST_DROP;
            end
          end else if (in_end_of_frame) begin
            pos_nxt = '0; dst_bc_nxt = 1'b1; hdr_words_nxt = '0;
          end
        end
      end
      ST_SUM: begin
        // Issue read of word idx; accumulate word read last cycle.
        if (idx_r != 6'd7) sum_nxt = add_full;
        rd_idx_nxt = idx_r;
        if (idx_r + 6'd1 == hdr_words_r) state_nxt = ST_SUM_FIN;
        else idx_nxt = idx_r + 6'd1;
      end
      ST_SUM_FIN: begin
        csum_nxt = ~(add_full[15:0] + {15'd0, add_full[16]});
        idx_nxt = 6'd0;
        rd_idx_nxt = 6'd0;
        state_nxt = ST_EMIT;
        mem_raddr = '0;
      end
      ST_EMIT: begin
        // mem_rdata_r holds word rd_idx_r here; idx_r == rd_idx_r.
        if (out_free) begin
          ov_nxt = 1'b1;
          ow_nxt = (rd_idx_r == 6'(POS_CSUM)) ? csum_r : rw_word;
          ol_nxt = eof_hdr_r && (rd_idx_r + 6'd1 == hdr_words_r);
          osb_nxt = 1'b0;
          oside_nxt = (cls_r == CLS_BCAST);
          if (rd_idx_r + 6'd1 == hdr_words_r) begin
            if (eof_hdr_r) begin
              state_nxt = ST_COLLECT; pos_nxt = '0; dst_bc_nxt = 1'b1;
              hdr_words_nxt = '0; cls_nxt = CLS_UNDECIDED;
            end else state_nxt = ST_STREAM;
          end else begin
            idx_nxt = rd_idx_r + 6'd1;
            rd_idx_nxt = rd_idx_r + 6'd1;
            mem_raddr = HDR_AW'(rd_idx_r + 6'd1);
          end
        end else mem_raddr = rd_idx_r[HDR_AW-1:0];
      end
      ST_STREAM: begin
        in_stall = !out_free;
        if (in_acc) begin
          ov_nxt = 1'b1;
          ow_nxt = (pos_r == 16'(POS_UDP_CSUM)) ? 16'h0000 : in_frame_word;
          ol_nxt = in_end_of_frame;
          osb_nxt = in_end_of_frame && in_single_byte;
          oside_nxt = (cls_r == CLS_BCAST);
          if (in_end_of_frame) begin
            state_nxt = ST_COLLECT; pos_nxt = '0; dst_bc_nxt = 1'b1;
            hdr_words_nxt = '0; cls_nxt = CLS_UNDECIDED;
          end else if (pos_r != 16'hFFFF) pos_nxt = pos_r + 16'd1;
        end
      end
      ST_DROP: begin
        in_stall = 1'b0;
        if (in_acc && in_end_of_frame) begin
          state_nxt = ST_COLLECT; pos_nxt = '0; dst_bc_nxt = 1'b1;
          hdr_words_nxt = '0; cls_nxt = CLS_UNDECIDED;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT; cls_r <= CLS_UNDECIDED; pos_r <= '0;
      hdr_words_r <= '0; idx_r <= '0; rd_idx_r <= '0; eof_hdr_r <= 1'b0;
      dst_bc_r <= 1'b1; sum_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cls_r <= cls_nxt; pos_r <= pos_nxt;
      hdr_words_r <= hdr_words_nxt; idx_r <= idx_nxt; rd_idx_r <= rd_idx_nxt;
      eof_hdr_r <= eof_hdr_nxt; dst_bc_r <= dst_bc_nxt; sum_r <= sum_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dip_r <= dip_nxt; csum_r <= csum_nxt;
    ow_r <= ow_nxt; ol_r <= ol_nxt; osb_r <= osb_nxt; oside_r <= oside_nxt;
  end

  assign out_valid       = ov_r;
  assign out_word        = ow_r;
  assign out_last        = ol_r;
  assign out_single_byte = osb_r;
  assign out_egress_side = oside_r;
endmodule
